// ----- rtl/bit_packed_vector_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Bit-packed vector unit assertion macros
// Shared concurrent assertion forms for the bit-packed vector unit checkers.
// ----------------------------------------------------------------------------
`ifndef BIT_PACKED_VECTOR_UNIT_MACROS_SVH
`define BIT_PACKED_VECTOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BPV_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BPV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpv_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit-packed vector package
// Word geometry, operation and status codes shared by the unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bpv_pkg;

    localparam int WORD_BITS       = 32;
    localparam int WORD_SHIFT      = 5;
    localparam int VALUE_BITS      = 32;
    localparam int INDEX_BITS      = 15;
    localparam int COUNT_BITS      = 16;
    localparam int WIDTH_BITS      = 6;
    localparam int STORE_WORDS_DEF = 1024;

    localparam logic                  OP_APPEND = 1'b0;
    localparam logic                  OP_READ   = 1'b1;

    localparam logic [1:0]            STAT_OK    = 2'd0;
    localparam logic [1:0]            STAT_RANGE = 2'd1;
    localparam logic [1:0]            STAT_FULL  = 2'd2;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 6'd8;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = 6'd32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

// ----- rtl/bit_packed_vector_unit.sv -----
// ----------------------------------------------------------------------------
// Bit-packed vector unit
// Packs elements of 1 to 32 bits MSB first into a single-port word store;
// appends at the tail and reads any element back by index.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_op, s_value, s_index
//  m_       out        m_valid / m_ready    m_read_value, m_status, m_element_count
//  cfg_     in         cfg_valid/cfg_ready  cfg_bits_per_value
//
//  Append: one store write, and a second one in S_WR2 when the element straddles a word.
//  Read: one registered store read per word, the second issued from S_RD0 when straddling.
//  Errors finish in the accept cycle. The single store port forces this sequencing.
//  Reset: synchronous, active low; the store keeps its contents.
//  A stalled m_ holds the finished transaction; s_ready drops until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_packed_vector_unit
    import bpv_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [VALUE_BITS-1:0] s_value,
    input  wire logic [INDEX_BITS-1:0] s_index,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [VALUE_BITS-1:0]      m_read_value,
    output logic [1:0]                 m_status,
    output logic [COUNT_BITS-1:0]      m_element_count,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [WIDTH_BITS-1:0] cfg_bits_per_value
);

    localparam int AW       = $clog2(STORE_WORDS);
    localparam int TW       = $clog2(STORE_WORDS + 1);
    localparam int POS_BITS = INDEX_BITS + WIDTH_BITS;
    localparam int RW_BITS  = POS_BITS - WORD_SHIFT;
    localparam int END_BITS = WIDTH_BITS + 1;

    localparam logic [TW-1:0]       LAST_IDX     = TW'(STORE_WORDS - 1);
    localparam logic [RW_BITS:0]    STORE_WORDS_L = (RW_BITS + 1)'(STORE_WORDS);
    localparam logic [END_BITS-1:0] WORD_END     = END_BITS'(WORD_BITS);
    localparam logic [END_BITS-1:0] PAIR_END     = END_BITS'(2 * WORD_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WR2,
        S_RD0,
        S_RD1
    } state_t;

    state_t                  state_reg, state_next;
    logic [WIDTH_BITS-1:0]   bits_reg, bits_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [WORD_SHIFT-1:0]   tail_off_reg, tail_off_next;
    logic [TW-1:0]           tail_idx_reg, tail_idx_next;
    logic [WORD_BITS-1:0]    tail_word_reg, tail_word_next;
    logic [WORD_BITS-1:0]    spill_word_reg, spill_word_next;
    logic [AW-1:0]           second_addr_reg, second_addr_next;
    logic [END_BITS-1:0]     rd_end_reg, rd_end_next;
    logic                    rd_straddle_reg, rd_straddle_next;
    logic [WORD_BITS-1:0]    word0_reg, word0_next;
    logic                    m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0]   m_read_value_reg, m_read_value_next;
    logic [1:0]              m_status_reg, m_status_next;
    logic [COUNT_BITS-1:0]   m_count_reg, m_count_next;

    logic [WORD_BITS-1:0]    mem [STORE_WORDS];
    logic [WORD_BITS-1:0]    rdata_reg;
    logic                    mem_we;
    logic                    mem_re;
    logic [AW-1:0]           mem_addr;
    logic [WORD_BITS-1:0]    mem_wdata;

    logic                    out_free;
    logic                    accept;
    logic [VALUE_BITS-1:0]   val_mask;
    logic [VALUE_BITS-1:0]   app_value;
    logic [END_BITS-1:0]     app_end;
    logic [2*WORD_BITS-1:0]  app_place;
    logic                    app_straddle;
    logic                    app_fit;
    logic [WORD_BITS-1:0]    app_head;
    logic [POS_BITS-1:0]     rd_pos;
    logic [RW_BITS-1:0]      rd_word;
    logic [END_BITS-1:0]     rd_end;
    logic                    rd_ok;
    logic [WORD_BITS-1:0]    ext_hi;
    logic [WORD_BITS-1:0]    ext_lo;
    logic [2*WORD_BITS-1:0]  ext_join;
    logic [VALUE_BITS-1:0]   ext_value;
    logic [WIDTH_BITS-1:0]   cfg_width;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid         = m_valid_reg;
    assign m_read_value    = m_read_value_reg;
    assign m_status        = m_status_reg;
    assign m_element_count = m_count_reg;

    assign val_mask = {VALUE_BITS{1'b1}} >> (WIDTH_MAX - bits_reg);

    assign app_value    = s_value & val_mask;
    assign app_end      = END_BITS'(tail_off_reg) + END_BITS'(bits_reg);
    assign app_place    = {{WORD_BITS{1'b0}}, app_value} << (PAIR_END - app_end);
    assign app_straddle = app_end > WORD_END;
    assign app_fit      = (count_reg != COUNT_MAX) &&
                          ((tail_idx_reg < LAST_IDX) ||
                           ((tail_idx_reg == LAST_IDX) && !app_straddle));
    assign app_head     = ((tail_off_reg == '0) ? '0 : tail_word_reg) |
                          app_place[2*WORD_BITS-1:WORD_BITS];

    assign rd_pos  = POS_BITS'(s_index) * POS_BITS'(bits_reg);
    assign rd_word = rd_pos[POS_BITS-1:WORD_SHIFT];
    assign rd_end  = END_BITS'(rd_pos[WORD_SHIFT-1:0]) + END_BITS'(bits_reg);
    assign rd_ok   = ({1'b0, s_index} < count_reg) && ({1'b0, rd_word} < STORE_WORDS_L);

    assign ext_hi    = (state_reg == S_RD1) ? word0_reg : rdata_reg;
    assign ext_lo    = (state_reg == S_RD1) ? rdata_reg : '0;
    assign ext_join  = {ext_hi, ext_lo} >> (PAIR_END - rd_end_reg);
    assign ext_value = ext_join[VALUE_BITS-1:0] & val_mask;

    always_comb begin
        if (cfg_bits_per_value == '0) begin
            cfg_width = WIDTH_BITS'(1);
        end else if (cfg_bits_per_value > WIDTH_MAX) begin
            cfg_width = WIDTH_MAX;
        end else begin
            cfg_width = cfg_bits_per_value;
        end
    end

    always_comb begin
        state_next        = state_reg;
        bits_next         = bits_reg;
        count_next        = count_reg;
        tail_off_next     = tail_off_reg;
        tail_idx_next     = tail_idx_reg;
        tail_word_next    = tail_word_reg;
        spill_word_next   = spill_word_reg;
        second_addr_next  = second_addr_reg;
        rd_end_next       = rd_end_reg;
        rd_straddle_next  = rd_straddle_reg;
        word0_next        = word0_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_read_value_next = m_read_value_reg;
        m_status_next     = m_status_reg;
        m_count_next      = m_count_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_addr          = tail_idx_reg[AW-1:0];
        mem_wdata         = app_head;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_op == OP_APPEND) begin
                        m_valid_next      = 1'b1;
                        m_read_value_next = '0;
                        if (app_fit) begin
                            mem_we           = 1'b1;
                            count_next       = count_reg + COUNT_BITS'(1);
                            tail_off_next    = app_end[WORD_SHIFT-1:0];
                            tail_idx_next    = tail_idx_reg + TW'(app_end[WORD_SHIFT]);
                            tail_word_next   = app_end[WORD_SHIFT] ?
                                               app_place[WORD_BITS-1:0] : app_head;
                            spill_word_next  = app_place[WORD_BITS-1:0];
                            second_addr_next = tail_idx_reg[AW-1:0] + AW'(1);
                            m_status_next    = STAT_OK;
                            m_count_next     = count_reg + COUNT_BITS'(1);
                            if (app_straddle) begin
                                state_next = S_WR2;
                            end
                        end else begin
                            m_status_next = STAT_FULL;
                            m_count_next  = count_reg;
                        end
                    end else begin
                        if (rd_ok) begin
                            mem_re           = 1'b1;
                            mem_addr         = rd_word[AW-1:0];
                            rd_end_next      = rd_end;
                            rd_straddle_next = rd_end > WORD_END;
                            second_addr_next = rd_word[AW-1:0] + AW'(1);
                            state_next       = S_RD0;
                        end else begin
                            m_valid_next      = 1'b1;
                            m_read_value_next = '0;
                            m_status_next     = STAT_RANGE;
                            m_count_next      = count_reg;
                        end
                    end
                end
            end
            S_WR2: begin
                mem_we     = 1'b1;
                mem_addr   = second_addr_reg;
                mem_wdata  = spill_word_reg;
                state_next = S_IDLE;
            end
            S_RD0: begin
                if (rd_straddle_reg) begin
                    mem_re     = 1'b1;
                    mem_addr   = second_addr_reg;
                    word0_next = rdata_reg;
                    state_next = S_RD1;
                end else if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_read_value_next = ext_value;
                    m_status_next     = STAT_OK;
                    m_count_next      = count_reg;
                    state_next        = S_IDLE;
                end
            end
            S_RD1: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_read_value_next = ext_value;
                    m_status_next     = STAT_OK;
                    m_count_next      = count_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            bits_next     = cfg_width;
            count_next    = '0;
            tail_off_next = '0;
            tail_idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            bits_reg     <= WIDTH_RESET;
            count_reg    <= '0;
            tail_off_reg <= '0;
            tail_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bits_reg     <= bits_next;
            count_reg    <= count_next;
            tail_off_reg <= tail_off_next;
            tail_idx_reg <= tail_idx_next;
            m_valid_reg  <= m_valid_next;
        end
        tail_word_reg    <= tail_word_next;
        spill_word_reg   <= spill_word_next;
        second_addr_reg  <= second_addr_next;
        rd_end_reg       <= rd_end_next;
        rd_straddle_reg  <= rd_straddle_next;
        word0_reg        <= word0_next;
        m_read_value_reg <= m_read_value_next;
        m_status_reg     <= m_status_next;
        m_count_reg      <= m_count_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            rdata_reg <= mem[mem_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bpv_checker.sv -----
// ----------------------------------------------------------------------------
// Bit-packed vector checker
// Port-level assertions on the result channel, bound to bit_packed_vector_unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_packed_vector_unit_macros.svh"

module bpv_checker
    import bpv_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [VALUE_BITS-1:0] m_read_value,
    input wire logic [1:0]            m_status,
    input wire logic [COUNT_BITS-1:0] m_element_count
);

    `BPV_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_value) && $stable(m_status) && $stable(m_element_count), "result transaction changed while stalled")

    `BPV_ASSERT_SAME(a_err_zero, aclk, aresetn, m_valid && (m_status != STAT_OK), m_read_value == '0, "failed transaction carries nonzero read value")

    `BPV_ASSERT_SAME(a_reset_idle, aclk, aresetn, $rose(aresetn), !m_valid, "result valid right after reset")

endmodule

bind bit_packed_vector_unit bpv_checker u_bpv_checker (.*);

`default_nettype wire

// ----- tb/bit_packed_vector_checker.sv -----
// ----------------------------------------------------------------------------
// Bit-packed vector checker
// Watches the input, result and width channels of the bit-packed vector unit,
// keeps its own packed word store, predicts one result per accepted input
// transaction and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module bit_packed_vector_checker
    import bpv_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_op,
    input  logic [VALUE_BITS-1:0] s_value,
    input  logic [INDEX_BITS-1:0] s_index,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [VALUE_BITS-1:0] m_read_value,
    input  logic [1:0]            m_status,
    input  logic [COUNT_BITS-1:0] m_element_count,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [WIDTH_BITS-1:0] cfg_bits_per_value,

    output int                    mismatches,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_BITS-1:0] read_value;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] element_count;
    } vector_result_t;

    logic [WORD_BITS-1:0] word_store [STORE_WORDS];
    int unsigned          elem_width;
    int unsigned          elem_count;
    int unsigned          tail_offset;
    int unsigned          tail_word;
    vector_result_t       due_results [$];

    function automatic logic [63:0] low_ones(int unsigned n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic int unsigned clamp_width(logic [WIDTH_BITS-1:0] raw);
        if (raw == '0)
            return 1;
        if (raw > WIDTH_MAX)
            return 32'(WIDTH_MAX);
        return 32'(raw);
    endfunction

    function automatic void empty_vector();
        elem_count  = 0;
        tail_offset = 0;
        tail_word   = 0;
    endfunction

    function automatic void enqueue_result(vector_result_t res);
        due_results = {due_results, res};
    endfunction

    function automatic vector_result_t pack_element(logic [VALUE_BITS-1:0] raw);
        vector_result_t   res;
        logic [63:0]      field;
        logic [63:0]      part;
        longint unsigned  free_bits;
        int unsigned      n1;
        int unsigned      n2;
        res   = '0;
        field = 64'(raw) & low_ones(elem_width);
        if (tail_word >= STORE_WORDS)
            free_bits = 0;
        else
            free_bits = longint'(STORE_WORDS - tail_word) * WORD_BITS - tail_offset;
        if (elem_width > free_bits || elem_count >= COUNT_MAX) begin
            res.status        = STAT_FULL;
            res.element_count = COUNT_BITS'(elem_count);
            return res;
        end
        if (tail_offset + elem_width <= WORD_BITS) begin
            part = field << (WORD_BITS - tail_offset - elem_width);
            if (tail_offset == 0)
                word_store[tail_word] = part[WORD_BITS-1:0];
            else
                word_store[tail_word] |= part[WORD_BITS-1:0];
        end else begin
            n1 = WORD_BITS - tail_offset;
            n2 = elem_width - n1;
            part = field >> n2;
            word_store[tail_word] |= part[WORD_BITS-1:0];
            if (tail_word + 1 < STORE_WORDS) begin
                part = field << (WORD_BITS - n2);
                word_store[tail_word + 1] = part[WORD_BITS-1:0];
            end
        end
        tail_offset += elem_width;
        if (tail_offset >= WORD_BITS) begin
            tail_offset -= WORD_BITS;
            tail_word++;
        end
        elem_count++;
        res.status        = STAT_OK;
        res.element_count = COUNT_BITS'(elem_count);
        return res;
    endfunction

    function automatic vector_result_t unpack_element(logic [INDEX_BITS-1:0] idx);
        vector_result_t res;
        logic [63:0]    pos;
        logic [63:0]    hi;
        logic [63:0]    lo;
        logic [63:0]    field;
        int unsigned    w;
        int unsigned    off;
        int unsigned    n1;
        int unsigned    n2;
        res               = '0;
        res.element_count = COUNT_BITS'(elem_count);
        if (idx >= elem_count) begin
            res.status = STAT_RANGE;
            return res;
        end
        pos = 64'(idx) * elem_width;
        w   = 32'(pos / WORD_BITS);
        off = 32'(pos % WORD_BITS);
        if (w >= STORE_WORDS) begin
            res.status = STAT_RANGE;
            return res;
        end
        if (off + elem_width <= WORD_BITS) begin
            field = (64'(word_store[w]) >> (WORD_BITS - off - elem_width))
                    & low_ones(elem_width);
        end else begin
            n1 = WORD_BITS - off;
            n2 = elem_width - n1;
            hi = 64'(word_store[w]) & low_ones(n1);
            lo = '0;
            if (w + 1 < STORE_WORDS)
                lo = 64'(word_store[w + 1]) >> (WORD_BITS - n2);
            field = ((hi << n2) | lo) & low_ones(elem_width);
        end
        res.read_value = field[VALUE_BITS-1:0];
        res.status     = STAT_OK;
        return res;
    endfunction

    always @(posedge aclk) begin
        vector_result_t want;
        if (!aresetn) begin
            elem_width = 32'(WIDTH_RESET);
            empty_vector();
            due_results.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                elem_width = clamp_width(cfg_bits_per_value);
                empty_vector();
            end
            if (s_valid && s_ready) begin
                if (s_op == OP_READ)
                    enqueue_result(unpack_element(s_index));
                else
                    enqueue_result(pack_element(s_value));
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (m_read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, m_read_value);
                        mismatches++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatches++;
                    end
                    if (m_element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, m_element_count);
                        mismatches++;
                    end
                end
            end
        end
        pending <= due_results.size();
    end

endmodule

// ----- tb/bit_packed_vector_unit_test.sv -----
// ----------------------------------------------------------------------------
// Bit-packed vector unit testbench
// Drives directed and random append and read transactions across several
// element widths, packs a run of full-width words, applies random backpressure
// and one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module bit_packed_vector_unit_test
    import bpv_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 150;
    localparam int WIDE_FILL   = 100;

    logic                  aclk;
    logic                  aresetn            = 1'b0;
    logic                  s_valid            = 1'b0;
    logic                  s_ready;
    logic                  s_op               = OP_APPEND;
    logic [VALUE_BITS-1:0] s_value            = '0;
    logic [INDEX_BITS-1:0] s_index            = '0;
    logic                  m_valid;
    logic                  m_ready            = 1'b0;
    logic [VALUE_BITS-1:0] m_read_value;
    logic [1:0]            m_status;
    logic [COUNT_BITS-1:0] m_element_count;
    logic                  cfg_valid          = 1'b0;
    logic                  cfg_ready;
    logic [WIDTH_BITS-1:0] cfg_bits_per_value = WIDTH_RESET;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int appended    = 0;
    bit steady_flow = 1'b0;
    bit stall_request = 1'b0;

    bit_packed_vector_unit #(
        .STORE_WORDS(STORE_WORDS_DEF)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_value           (s_value),
        .s_index           (s_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_value      (m_read_value),
        .m_status          (m_status),
        .m_element_count   (m_element_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_bits_per_value(cfg_bits_per_value)
    );

    bit_packed_vector_checker #(
        .STORE_WORDS(STORE_WORDS_DEF)
    ) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_value           (s_value),
        .s_index           (s_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_value      (m_read_value),
        .m_status          (m_status),
        .m_element_count   (m_element_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_bits_per_value(cfg_bits_per_value),
        .mismatches        (mismatches),
        .pending           (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic op, input logic [VALUE_BITS-1:0] val,
                             input logic [INDEX_BITS-1:0] idx);
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= val;
        s_index <= idx;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_APPEND)
            appended++;
        if (!steady_flow && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_width(input logic [WIDTH_BITS-1:0] raw);
        drain_results();
        cfg_valid          <= 1'b1;
        cfg_bits_per_value <= raw;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        appended = 0;
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_mix(input logic [WIDTH_BITS-1:0] raw, input int count);
        logic [INDEX_BITS-1:0] idx;
        write_width(raw);
        for (int i = 0; i < count; i++) begin
            if (appended == 0 || $urandom_range(0, 99) < 55) begin
                send_item(OP_APPEND, pick_value(), INDEX_BITS'($urandom));
            end else begin
                if ($urandom_range(0, 6) == 0)
                    idx = INDEX_BITS'($urandom_range(0, 32767));
                else
                    idx = INDEX_BITS'($urandom_range(0, appended));
                send_item(OP_READ, $urandom, idx);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(OP_READ,   32'h0000_0000, 15'd0);
        send_item(OP_APPEND, 32'hFFFF_FFFF, 15'd0);
        send_item(OP_APPEND, 32'h0000_0000, 15'd0);
        send_item(OP_APPEND, 32'hA5A5_A5C3, 15'd0);
        send_item(OP_APPEND, 32'h1234_5601, 15'd0);
        send_item(OP_APPEND, 32'h0000_0080, 15'd0);
        send_item(OP_READ,   32'h0000_0000, 15'd0);
        send_item(OP_READ,   32'h0000_0000, 15'd4);
        send_item(OP_READ,   32'h0000_0000, 15'd5);
        send_item(OP_READ,   32'hFFFF_FFFF, 15'h7FFF);

        write_width(6'd0);
        send_item(OP_APPEND, 32'hFFFF_FFFE, 15'd0);
        send_item(OP_APPEND, 32'h0000_0001, 15'd0);
        send_item(OP_READ,   32'h0000_0000, 15'd1);

        write_width(6'd63);
        send_item(OP_APPEND, 32'hFFFF_FFFF, 15'd0);
        send_item(OP_APPEND, 32'h0000_0000, 15'd0);
        send_item(OP_READ,   32'h0000_0000, 15'd0);

        // element six straddles the first word boundary
        write_width(6'd5);
        send_item(OP_APPEND, 32'd31, 15'd0);
        send_item(OP_APPEND, 32'd0,  15'd0);
        send_item(OP_APPEND, 32'd21, 15'd0);
        send_item(OP_APPEND, 32'd10, 15'd0);
        send_item(OP_APPEND, 32'd31, 15'd0);
        send_item(OP_APPEND, 32'd17, 15'd0);
        send_item(OP_APPEND, 32'hFFFF_FFFF, 15'd0);
        send_item(OP_READ,   32'd0, 15'd6);
        send_item(OP_READ,   32'd0, 15'd5);

        // pack a run of full-width words
        write_width(6'd32);
        while (appended < WIDE_FILL) begin
            if ($urandom_range(0, 5) == 0)
                send_item(OP_READ, $urandom, INDEX_BITS'($urandom_range(0, appended)));
            else
                send_item(OP_APPEND, $urandom, INDEX_BITS'($urandom));
        end

        run_mix(6'd1, 100);
        drain_results();
        stall_request = 1'b1;
        run_mix(6'd33, 100);
        run_mix(WIDTH_BITS'($urandom_range(2, 31)), 100);
        run_mix(WIDTH_BITS'($urandom_range(0, 63)), 100);
        run_mix(6'd3, 100);
        drain_results();
        steady_flow = 1'b1;
        run_mix(WIDTH_BITS'($urandom_range(1, 32)), 100);

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
